// ===== rtl/dqhr_pkg.sv =====
// Shared types and constants for the half-rotate deque.
// Request/response payload structs, action and status codes, store geometry.
// No dependencies.
`default_nettype none

package dqhr_pkg;

    localparam int CAPACITY = 1024;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic [2:0] ACT_PUSH_HEAD = 3'd0;
    localparam logic [2:0] ACT_PUSH_TAIL = 3'd1;
    localparam logic [2:0] ACT_POP_HEAD  = 3'd2;
    localparam logic [2:0] ACT_POP_TAIL  = 3'd3;
    localparam logic [2:0] ACT_ROTATE    = 3'd4;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_POPPED = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [2:0]               action;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] popped_value;
        logic [COUNT_W-1:0]       entry_count;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/dqhr_ram.sv =====
// Single-port-write, single-port-read RAM with registered read data.
// Read data holds until the next read enable. No dependencies.
`default_nettype none

module dqhr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/deque_with_half_rotate.sv =====
// Top level of the half-rotate deque: sequencer, list pointers, slot allocator.
// Uses dqhr_pkg and three dqhr_ram instances (entries, next links, prev links).
//
//   channel   | signals                  | transfer when
//   ----------+--------------------------+------------------------------
//   request   | start, busy, i_req       | start high and busy low
//   response  | o_rsp_valid, o_rsp       | o_rsp_valid high (one cycle)
//
// Each request runs in steps: the accept cycle issues the first memory
// reads, S_RD2 reads the links of the middle entry, S_WR writes the link
// memories and updates the pointers. The response strobe follows, in the
// cycle in which busy is already low again; no new request is taken before then.
// The single read port on each link memory forces the separate S_RD2 read.
// Reset is synchronous; store contents are not cleared, so no clearing pass.
// The receiver cannot stall the response.
`default_nettype none

module deque_with_half_rotate
    import dqhr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    output t_rsp      o_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD2  = 2'd1;
    localparam logic [1:0] S_WR   = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [2:0]         r_act;
    logic [DATA_W-1:0]  r_val;
    logic [SLOT_W-1:0]  r_front, n_front;
    logic [SLOT_W-1:0]  r_back, n_back;
    logic [SLOT_W-1:0]  r_mid, n_mid;
    logic               r_par, n_par;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_fresh, n_fresh;
    logic [SLOT_W-1:0]  r_spare_head, n_spare_head;
    logic [COUNT_W-1:0] r_spare_len, n_spare_len;
    logic [SLOT_W-1:0]  r_nl1, r_pl1;
    logic               r_rsp_valid;
    t_rsp               r_rsp, n_rsp;

    logic               accept;
    logic               req_push;

    logic               ent_we, ent_re;
    logic [SLOT_W-1:0]  ent_waddr, ent_raddr;
    logic [DATA_W-1:0]  ent_rdata;

    logic               nl_we, nl_re;
    logic [SLOT_W-1:0]  nl_waddr, nl_wdata, nl_raddr, nl_rdata;

    logic               pl_we, pl_re;
    logic [SLOT_W-1:0]  pl_waddr, pl_wdata, pl_raddr, pl_rdata;

    logic [SLOT_W-1:0]  slot;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_comb begin
        req_push = (i_req.action inside {ACT_PUSH_HEAD, ACT_PUSH_TAIL});
    end

    // First read in the accept cycle, middle-entry links in the S_RD2 state.
    assign ent_re    = accept;
    assign ent_raddr = (i_req.action == ACT_POP_HEAD) ? r_front : r_back;
    assign nl_re     = accept || (r_state == S_RD2);
    assign pl_re     = nl_re;
    assign nl_raddr  = (r_state == S_RD2) ? r_mid : (req_push ? r_spare_head : r_front);
    assign pl_raddr  = (r_state == S_RD2) ? r_mid : r_back;

    dqhr_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_entry (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (r_val),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    dqhr_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_next (
        .i_clk   (i_clk),
        .i_we    (nl_we),
        .i_waddr (nl_waddr),
        .i_wdata (nl_wdata),
        .i_re    (nl_re),
        .i_raddr (nl_raddr),
        .o_rdata (nl_rdata)
    );

    dqhr_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_prev (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (pl_waddr),
        .i_wdata (pl_wdata),
        .i_re    (pl_re),
        .i_raddr (pl_raddr),
        .o_rdata (pl_rdata)
    );

    // Slot for a push: head of the spare list, else the next fresh slot.
    assign slot = (r_spare_len != '0) ? r_spare_head : r_fresh[SLOT_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_back       = r_back;
        n_mid        = r_mid;
        n_par        = r_par;
        n_count      = r_count;
        n_fresh      = r_fresh;
        n_spare_head = r_spare_head;
        n_spare_len  = r_spare_len;
        n_rsp        = r_rsp;
        ent_we       = 1'b0;
        ent_waddr    = slot;
        nl_we        = 1'b0;
        nl_waddr     = slot;
        nl_wdata     = r_front;
        pl_we        = 1'b0;
        pl_waddr     = r_front;
        pl_wdata     = slot;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_RD2;
                end
            end
            S_RD2: begin
                n_state = S_WR;
            end
            S_WR: begin
                n_state = S_IDLE;
                n_rsp.status       = ST_DONE;
                n_rsp.popped_value = '0;
                case (r_act)
                    ACT_PUSH_HEAD, ACT_PUSH_TAIL: begin
                        if (r_count >= COUNT_W'(CAPACITY)) begin
                            n_rsp.status = ST_FULL;
                        end else begin
                            if (r_spare_len != '0) begin
                                n_spare_head = r_nl1;
                                n_spare_len  = r_spare_len - COUNT_W'(1);
                            end else begin
                                n_fresh = r_fresh + COUNT_W'(1);
                            end
                            ent_we = 1'b1;
                            if (r_count == '0) begin
                                n_front = slot;
                                n_back  = slot;
                                n_mid   = slot;
                                n_par   = 1'b0;
                            end else if (r_act == ACT_PUSH_HEAD) begin
                                nl_we    = 1'b1;
                                nl_waddr = slot;
                                nl_wdata = r_front;
                                pl_we    = 1'b1;
                                pl_waddr = r_front;
                                pl_wdata = slot;
                                // prev link of mid was read before front's link changed
                                if (r_par) begin
                                    n_mid = (r_mid == r_front) ? slot : pl_rdata;
                                end
                                n_par   = ~r_par;
                                n_front = slot;
                            end else begin
                                pl_we    = 1'b1;
                                pl_waddr = slot;
                                pl_wdata = r_back;
                                nl_we    = 1'b1;
                                nl_waddr = r_back;
                                nl_wdata = slot;
                                if (!r_par) begin
                                    n_mid = (r_mid == r_back) ? slot : nl_rdata;
                                end
                                n_par  = ~r_par;
                                n_back = slot;
                            end
                            n_count = r_count + COUNT_W'(1);
                        end
                    end
                    ACT_POP_HEAD, ACT_POP_TAIL: begin
                        if (r_count == '0) begin
                            n_rsp.status = ST_EMPTY;
                        end else begin
                            n_rsp.status       = ST_POPPED;
                            n_rsp.popped_value = ent_rdata;
                            if (r_count == COUNT_W'(1)) begin
                                n_par = 1'b0;
                            end else if (r_act == ACT_POP_HEAD) begin
                                n_front = r_nl1;
                                if (!r_par) begin
                                    n_mid = nl_rdata;
                                end
                                n_par = ~r_par;
                            end else begin
                                n_back = r_pl1;
                                if (r_par) begin
                                    n_mid = pl_rdata;
                                end
                                n_par = ~r_par;
                            end
                            // released slot goes on the spare list
                            nl_we        = 1'b1;
                            nl_waddr     = (r_act == ACT_POP_HEAD) ? r_front : r_back;
                            nl_wdata     = r_spare_head;
                            n_spare_head = nl_waddr;
                            n_spare_len  = r_spare_len + COUNT_W'(1);
                            n_count      = r_count - COUNT_W'(1);
                        end
                    end
                    ACT_ROTATE: begin
                        if (r_count >= COUNT_W'(2)) begin
                            nl_we    = 1'b1;
                            nl_waddr = r_back;
                            nl_wdata = r_front;
                            pl_we    = 1'b1;
                            pl_waddr = r_front;
                            pl_wdata = r_back;
                            n_front  = r_mid;
                            n_back   = pl_rdata;
                            n_mid    = r_count[0] ? r_back : r_front;
                        end
                    end
                    default: begin
                    end
                endcase
                n_rsp.entry_count = n_count;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_front      <= '0;
            r_back       <= '0;
            r_mid        <= '0;
            r_par        <= 1'b0;
            r_count      <= '0;
            r_fresh      <= '0;
            r_spare_head <= '0;
            r_spare_len  <= '0;
            r_rsp_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_front      <= n_front;
            r_back       <= n_back;
            r_mid        <= n_mid;
            r_par        <= n_par;
            r_count      <= n_count;
            r_fresh      <= n_fresh;
            r_spare_head <= n_spare_head;
            r_spare_len  <= n_spare_len;
            r_rsp_valid  <= (r_state == S_WR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act <= i_req.action;
            r_val <= i_req.value;
        end
        if (r_state == S_RD2) begin
            r_nl1 <= nl_rdata;
            r_pl1 <= pl_rdata;
        end
        r_rsp <= n_rsp;
    end

    a_rsp_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_rsp_valid)
        else $error("response strobe not three cycles after accept");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.entry_count <= COUNT_W'(CAPACITY)))
        else $error("entry count above capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp.status == ST_FULL))
            |-> (o_rsp.entry_count == COUNT_W'(CAPACITY)))
        else $error("push dropped while store not full");

    a_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp.status != ST_POPPED)) |-> (o_rsp.popped_value == '0))
        else $error("popped value nonzero without a pop");

endmodule

`default_nettype wire
